// File: sv/flq_pkg.sv
// Shared types and constants for the frequency lock qualifier.
// Used by flq_front, flq_queue, flq_back and frequency_lock_qualifier_core.
// No dependencies.
package flq_pkg;

   localparam int FreqW      = 27;
   localparam int StepW      = 20;
   localparam int HitW       = 2;
   localparam int CsrAddrW   = 4;
   localparam int CsrDataW   = 32;
   localparam int ReqDataW   = 32;
   localparam int RspDataW   = 40;

   // Carrier frequencies are in 10 Hz units.
   localparam logic [FreqW-1:0] BcastLow    = 27'd8800000;
   localparam logic [FreqW-1:0] BcastHigh   = 27'd10800000;
   localparam logic [FreqW-1:0] MatchWindow = 27'd300;

   localparam logic [HitW-1:0] HitsToLock     = 2'd2;
   localparam logic [1:0]      ToggleInterval = 2'd2;

   // Register reset values.
   localparam logic [FreqW-1:0] BandBoundReset = 27'd28000000;
   localparam logic [StepW-1:0] StepSizeReset  = 20'd1250;

   // Register indexes (paddr[3:2]).
   localparam logic [1:0] RegBandBound  = 2'd0;
   localparam logic [1:0] RegRoundEn    = 2'd1;
   localparam logic [1:0] RegStepSize   = 2'd2;
   localparam logic [1:0] RegAutoSwitch = 2'd3;

   // Word queue between front and back.
   localparam int QueueDepth = 2;
   localparam int QPtrW      = $clog2(QueueDepth);
   localparam int QCntW      = $clog2(QueueDepth + 1);

   // Serial remainder unit: one dividend bit per cycle.
   localparam int DivSteps = FreqW;
   localparam int DivCntW  = $clog2(DivSteps);

   typedef struct packed {
      logic [FreqW-1:0] band_bound;
      logic             round_enable;
      logic [StepW-1:0] step_size;
      logic             auto_switch_enable;
   } cfg_type;

   // Result word; laid out so that the packed form is the tdata order.
   typedef struct packed {
      logic [HitW-1:0]  hit_level;
      logic             band_is_uhf;
      logic             freq_valid;
      logic             restart_scan;
      logic [FreqW-1:0] tuned_freq;
      logic             locked;
   } rsp_type;

endpackage

// File: sv/flq_front.sv
// Front end: accepts request words, keeps band, hit and toggle state,
// and pushes a classified result word (tuned_freq still unrounded). Uses flq_pkg.
module flq_front (
   input  logic             clock,
   input  logic             reset,
   input  flq_pkg::cfg_type cfg,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_mode,
   input  logic [26:0]      req_measured_freq,
   input  logic             q_ready,
   output logic             q_push,
   output flq_pkg::rsp_type q_word
);
   import flq_pkg::*;

   logic             uhf_ff, uhf_in;
   logic [FreqW-1:0] prev_ff, prev_in;
   logic [HitW-1:0]  hit_ff, hit_in;
   logic [1:0]       tog_ff, tog_in;

   logic             in_bcast;
   logic             band_ok;
   logic             valid;
   logic [FreqW-1:0] diff;
   logic [HitW-1:0]  hit_step;
   logic [1:0]       tog_step;
   logic             lock;

   assign req_tready = q_ready;
   assign q_push     = req_tvalid && q_ready;

   always_comb begin
      in_bcast = (req_measured_freq >= BcastLow) && (req_measured_freq <= BcastHigh);
      band_ok  = uhf_ff ? (req_measured_freq >= cfg.band_bound)
                        : (req_measured_freq <  cfg.band_bound);
      valid    = !in_bcast && band_ok;
      diff     = (req_measured_freq >= prev_ff) ? (req_measured_freq - prev_ff)
                                                : (prev_ff - req_measured_freq);
      hit_step = (valid && diff < MatchWindow) ? hit_ff + 2'd1 : 2'd1;
      lock     = hit_step >= HitsToLock;
      tog_step = cfg.auto_switch_enable ? tog_ff + 2'd1 : tog_ff;

      uhf_in  = uhf_ff;
      prev_in = prev_ff;
      hit_in  = hit_ff;
      tog_in  = tog_ff;
      q_word  = '0;

      if (req_mode) begin
         // Manual toggle: flip band, keep match history.
         uhf_in = !uhf_ff;
         tog_in = 2'd0;
      end else begin
         prev_in = req_measured_freq;
         hit_in  = lock ? 2'd0 : hit_step;
         tog_in  = tog_step;
         if (cfg.auto_switch_enable && tog_step >= ToggleInterval) begin
            uhf_in = !uhf_ff;
            tog_in = 2'd0;
         end
         q_word.locked       = lock;
         q_word.tuned_freq   = lock ? req_measured_freq : '0;
         q_word.restart_scan = !lock;
         q_word.freq_valid   = valid;
      end
      q_word.band_is_uhf = uhf_in;
      q_word.hit_level   = hit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         uhf_ff  <= 1'b0;
         prev_ff <= '0;
         hit_ff  <= '0;
         tog_ff  <= '0;
      end else if (q_push) begin
         uhf_ff  <= uhf_in;
         prev_ff <= prev_in;
         hit_ff  <= hit_in;
         tog_ff  <= tog_in;
      end
   end

endmodule

// File: sv/flq_queue.sv
// Short word queue between front and back end.
// Uses flq_pkg for the word type and depth.
module flq_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  flq_pkg::rsp_type push_word,
   output logic             push_ready,
   input  logic             pop,
   output logic             pop_valid,
   output flq_pkg::rsp_type pop_word
);
   import flq_pkg::*;

   rsp_type          mem [QueueDepth];
   logic [QPtrW-1:0] wr_ff, rd_ff;
   logic [QCntW-1:0] cnt_ff;

   assign push_ready = cnt_ff != QCntW'(QueueDepth);
   assign pop_valid  = cnt_ff != '0;
   assign pop_word   = mem[rd_ff];

   function automatic logic [QPtrW-1:0] next_ptr(input logic [QPtrW-1:0] p);
      next_ptr = (p == QPtrW'(QueueDepth - 1)) ? '0 : p + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (push) mem[wr_ff] <= push_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= next_ptr(wr_ff);
         if (pop)  rd_ff <= next_ptr(rd_ff);
         if (push && !pop)      cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

endmodule

// File: sv/flq_back.sv
// Back end: pops classified words, floors locked frequencies to the step
// with a bit-serial remainder unit, and holds the result register. Uses flq_pkg.
module flq_back (
   input  logic             clock,
   input  logic             reset,
   input  flq_pkg::cfg_type cfg,
   input  logic             q_valid,
   input  flq_pkg::rsp_type q_word,
   output logic             q_pop,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output flq_pkg::rsp_type rsp_word
);
   import flq_pkg::*;

   typedef enum logic {
      BK_IDLE,
      BK_DIV
   } state_type;

   state_type          state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   rsp_type            hold_ff, hold_in;
   logic [FreqW-1:0]   dvd_ff, dvd_in;
   logic [StepW-1:0]   rem_ff, rem_in;
   logic [DivCntW-1:0] cnt_ff, cnt_in;

   logic               out_free;
   logic               need_round;
   logic [StepW:0]     trial;
   logic [StepW-1:0]   rem_step;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_word   = rsp_ff;

   always_comb begin
      out_free   = !rsp_valid_ff || rsp_tready;
      need_round = q_word.locked && cfg.round_enable && (cfg.step_size != '0);
      trial      = {rem_ff, dvd_ff[FreqW-1]};
      rem_step   = (trial >= {1'b0, cfg.step_size}) ? StepW'(trial - {1'b0, cfg.step_size})
                                                    : trial[StepW-1:0];

      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      hold_in      = hold_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      q_pop        = 1'b0;

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid && out_free) begin
               q_pop = 1'b1;
               if (need_round) begin
                  hold_in  = q_word;
                  dvd_in   = q_word.tuned_freq;
                  rem_in   = '0;
                  cnt_in   = '0;
                  state_in = BK_DIV;
               end else begin
                  rsp_in       = q_word;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         BK_DIV: begin
            // Advance one dividend bit; result = freq - (freq mod step).
            rem_in = rem_step;
            dvd_in = {dvd_ff[FreqW-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DivCntW'(DivSteps - 1)) begin
               rsp_in            = hold_ff;
               rsp_in.tuned_freq = hold_ff.tuned_freq - {{(FreqW-StepW){1'b0}}, rem_step};
               rsp_valid_in      = 1'b1;
               state_in          = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff  <= rsp_in;
      hold_ff <= hold_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
   end

endmodule

// File: sv/frequency_lock_qualifier_core.sv
// Top level of the frequency lock qualifier: register file, front end,
// word queue and back end. Depends on flq_pkg, flq_front, flq_queue, flq_back.
//
// Usage:
//   req_* stream: one word per measurement (tuser = mode, tdata = frequency).
//     Mode 1 is a manual band toggle and yields a word with only band and
//     hit level set.
//   rsp_* stream: exactly one result word per request word, in order.
//   csr_* port: APB-style, four registers at byte addresses 0, 4, 8, 12.
//     Write registers only while no request word is outstanding.
// Path: a word passes through the queue into the result register; a locked
//   frequency with rounding on and a nonzero step first goes through the
//   bit-serial remainder unit in the back end (one dividend bit per cycle,
//   27 bits).
// Throughput: the front end takes a word per cycle while the two-word
//   queue has room; sustained rate is one word per cycle without rounding
//   while rsp_tready is high; no word is popped while a rounding runs.
// Reset: synchronous; state returns to VHF band, zero hits and zero
//   history, registers take their defaults, queue and result register
//   empty. No clearing pass is needed.
// Stall: a held result stays in the output register; the queue fills,
//   then req_tready drops until rsp_tready frees the path.
module frequency_lock_qualifier_core (
   input  logic                         clock,
   input  logic                         reset,
   // Request stream
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [flq_pkg::ReqDataW-1:0] req_tdata,   // [26:0] measured_freq, rest zero
   input  logic                         req_tuser,   // [0] mode
   // Result stream
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   // [0] locked, [27:1] tuned_freq, [28] restart_scan, [29] freq_valid,
   // [30] band_is_uhf, [32:31] hit_level, rest zero
   output logic [flq_pkg::RspDataW-1:0] rsp_tdata,
   // Register port
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [flq_pkg::CsrAddrW-1:0] csr_paddr,
   input  logic [flq_pkg::CsrDataW-1:0] csr_pwdata,
   output logic [flq_pkg::CsrDataW-1:0] csr_prdata,
   output logic                         csr_pready
);
   import flq_pkg::*;

   cfg_type    cfg_ff;
   logic       csr_wr;
   logic [1:0] csr_idx;

   logic       q_push, q_ready, q_pop, q_valid;
   rsp_type    q_in_word, q_out_word, rsp_word;

   // Register file: write on the access phase, read back as stored.
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.band_bound         <= BandBoundReset;
         cfg_ff.round_enable       <= 1'b1;
         cfg_ff.step_size          <= StepSizeReset;
         cfg_ff.auto_switch_enable <= 1'b1;
      end else if (csr_wr) begin
         unique case (csr_idx)
            RegBandBound:  cfg_ff.band_bound         <= csr_pwdata[FreqW-1:0];
            RegRoundEn:    cfg_ff.round_enable       <= csr_pwdata[0];
            RegStepSize:   cfg_ff.step_size          <= csr_pwdata[StepW-1:0];
            RegAutoSwitch: cfg_ff.auto_switch_enable <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         RegBandBound:  csr_prdata = {{(CsrDataW-FreqW){1'b0}}, cfg_ff.band_bound};
         RegRoundEn:    csr_prdata = {{(CsrDataW-1){1'b0}}, cfg_ff.round_enable};
         RegStepSize:   csr_prdata = {{(CsrDataW-StepW){1'b0}}, cfg_ff.step_size};
         RegAutoSwitch: csr_prdata = {{(CsrDataW-1){1'b0}}, cfg_ff.auto_switch_enable};
         default:       csr_prdata = '0;
      endcase
   end

   // Classify and update lock state as words arrive.
   flq_front u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_mode          (req_tuser),
      .req_measured_freq (req_tdata[FreqW-1:0]),
      .q_ready           (q_ready),
      .q_push            (q_push),
      .q_word            (q_in_word)
   );

   // Decouple the front end from a back end busy rounding.
   flq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_word  (q_in_word),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_word   (q_out_word)
   );

   // Round locked frequencies and hold the result word.
   flq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_word     (q_out_word),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_word   (rsp_word)
   );

   assign rsp_tdata = {{(RspDataW-$bits(rsp_type)){1'b0}}, rsp_word};

endmodule
